[sv/crrp_pkg.sv]
// ----------------------------------------------------------------------------
// crrp_pkg
// Shared types, constants and helpers of the reselection-rank record parser.
// ----------------------------------------------------------------------------
package crrp_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam logic [9:0] OFFSET_MAX = 10'd1023;

    typedef enum logic [2:0] {
        KIND_SERVING_3G  = 3'd0,
        KIND_NEIGHBOR_3G = 3'd1,
        KIND_GSM         = 3'd2,
        KIND_DONE        = 3'd3,
        KIND_TOO_SHORT   = 3'd4,
        KIND_BAD_VERSION = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        VER_0    = 2'd0,
        VER_1    = 2'd1,
        VER_2    = 2'd2,
        VER_NONE = 2'd3
    } t_version;

    typedef struct packed {
        t_kind              kind;
        logic [13:0]        channel;
        logic [8:0]         code;
        logic signed [8:0]  rscp;
        logic signed [6:0]  ecio;
        logic [7:0]         bsic;
        logic signed [7:0]  level;
        logic               eop;
    } t_item;

    function automatic logic [9:0] start_offset(input t_version v);
        logic [9:0] r;
        case (v)
            VER_0:   r = 10'd2;
            VER_1:   r = 10'd2;
            VER_2:   r = 10'd7;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] umts_stride(input t_version v);
        logic [4:0] r;
        case (v)
            VER_0:   r = 5'd10;
            VER_1:   r = 5'd11;
            VER_2:   r = 5'd16;
            default: r = 5'd1;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] gsm_stride(input t_version v);
        logic [4:0] r;
        case (v)
            VER_0:   r = 5'd7;
            VER_1:   r = 5'd8;
            VER_2:   r = 5'd13;
            default: r = 5'd1;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] cap_count(input logic [5:0] c);
        return (c > 6'(MAX_ENTRIES)) ? 6'(MAX_ENTRIES) : c;
    endfunction

    // raw - 21, clamped to -140..0
    function automatic logic signed [8:0] rscp_of(input logic [7:0] raw);
        logic signed [8:0] v;
        v = $signed({raw[7], raw}) - 9'sd21;
        if (v < -9'sd140) begin
            v = -9'sd140;
        end else if (v > 9'sd0) begin
            v = 9'sd0;
        end
        return v;
    endfunction

    // raw / 2 toward zero, clamped to -50..0
    function automatic logic signed [6:0] ecio_of(input logic [7:0] raw);
        logic signed [7:0] s;
        logic signed [7:0] h;
        s = $signed(raw);
        if (s[7]) begin
            h = (s + 8'sd1) >>> 1;
        end else begin
            h = s >>> 1;
        end
        if (h < -8'sd50) begin
            h = -8'sd50;
        end else if (h > 8'sd0) begin
            h = 8'sd0;
        end
        return h[6:0];
    endfunction

endpackage

[sv/cell_reselection_rank_record_parser_core.sv]
// ----------------------------------------------------------------------------
// cell_reselection_rank_record_parser_core
// Byte-wide parser of a reselection-rank log payload: emits one item per
// kept 3G or GSM record and one status item at the end of every packet.
// A byte is parsed in its accept cycle; its items are written into the result queue.
// One byte per cycle while ready; a byte that ends a record and a packet yields two
//   items, drained through a four-entry result queue at one item per cycle while the
//   output is ready. Input ready drops while fewer than two queue entries are free.
// Reset (i_rst_n low, synchronous) clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
module cell_reselection_rank_record_parser_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_last_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [2:0]               o_item_kind,
    output logic [13:0]              o_channel_number,
    output logic [8:0]               o_scrambling_code,
    output logic signed [8:0]        o_rscp_dbm,
    output logic signed [6:0]        o_ecio_db,
    output logic [7:0]               o_base_station_code,
    output logic signed [7:0]        o_gsm_level,
    output logic                     o_end_of_packet
);
    import crrp_pkg::*;

    logic [9:0]  r_offset,   n_offset;
    t_version    r_version,  n_version;
    logic [5:0]  r_umts_cnt, n_umts_cnt;
    logic [5:0]  r_gsm_cnt,  n_gsm_cnt;
    logic        r_in_gsm,   n_in_gsm;
    logic [5:0]  r_index,    n_index;
    logic [4:0]  r_pos,      n_pos;
    logic [15:0] r_channel,  n_channel;
    logic [15:0] r_code,     n_code;
    logic [7:0]  r_power,    n_power;
    logic [7:0]  r_bsic,     n_bsic;
    logic        r_serving,  n_serving;

    t_item                 r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    logic        in_acc;
    logic        out_acc;
    logic        rec_valid;
    t_item       rec_item;
    t_item       stat_item;
    t_item       slot0;
    logic [1:0]  push_cnt;
    logic [4:0]  pos_inc;
    logic [5:0]  idx_inc;
    logic [11:0] arfcn;
    t_item       head;

    assign o_in_ready  = (r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign in_acc      = i_in_valid & o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign out_acc     = o_out_valid & i_out_ready;

    assign pos_inc = r_pos + 5'd1;
    assign idx_inc = r_index + 6'd1;
    assign arfcn   = r_channel[11:0];

    always_comb begin
        n_offset   = r_offset;
        n_version  = r_version;
        n_umts_cnt = r_umts_cnt;
        n_gsm_cnt  = r_gsm_cnt;
        n_in_gsm   = r_in_gsm;
        n_index    = r_index;
        n_pos      = r_pos;
        n_channel  = r_channel;
        n_code     = r_code;
        n_power    = r_power;
        n_bsic     = r_bsic;
        n_serving  = r_serving;
        rec_valid  = 1'b0;
        rec_item   = '0;
        stat_item  = '0;

        if (r_offset == 10'd0) begin
            n_version  = t_version'(i_data_byte[7:6]);
            n_umts_cnt = cap_count(i_data_byte[5:0]);
        end else if (r_offset == 10'd1) begin
            n_gsm_cnt = cap_count(i_data_byte[5:0]);
            n_in_gsm  = (r_umts_cnt == 6'd0);
            n_index   = '0;
            n_pos     = '0;
        end else if (r_version != VER_NONE && r_offset >= start_offset(r_version)) begin
            if (r_in_gsm) begin
                if (r_index < r_gsm_cnt) begin
                    case (r_pos)
                        5'd0: n_channel = {8'd0, i_data_byte};
                        5'd1: n_channel = {i_data_byte, r_channel[7:0]};
                        5'd2: n_bsic    = i_data_byte;
                        5'd3: n_power   = i_data_byte;
                        5'd4: begin
                            if (arfcn[11:10] == 2'd0 && arfcn[9:0] != 10'd0) begin
                                rec_valid        = 1'b1;
                                rec_item.kind    = KIND_GSM;
                                rec_item.channel = {2'd0, arfcn};
                                rec_item.bsic    = r_bsic;
                                rec_item.level   = $signed(r_power);
                            end
                        end
                        default: ;
                    endcase
                    if (pos_inc >= gsm_stride(r_version)) begin
                        n_pos   = '0;
                        n_index = idx_inc;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
            end else if (r_index < r_umts_cnt) begin
                case (r_pos)
                    5'd0: n_channel = {8'd0, i_data_byte};
                    5'd1: n_channel = {i_data_byte, r_channel[7:0]};
                    5'd2: n_code    = {8'd0, i_data_byte};
                    5'd3: n_code    = {i_data_byte, r_code[7:0]};
                    5'd4: n_power   = i_data_byte;
                    5'd7: begin
                        if (r_code[15:9] == 7'd0 && r_channel[15:14] == 2'd0
                                && r_channel[13:0] != 14'd0) begin
                            rec_valid        = 1'b1;
                            rec_item.kind    = r_serving ? KIND_NEIGHBOR_3G : KIND_SERVING_3G;
                            rec_item.channel = r_channel[13:0];
                            rec_item.code    = r_code[8:0];
                            rec_item.rscp    = rscp_of(r_power);
                            rec_item.ecio    = ecio_of(i_data_byte);
                            n_serving        = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (pos_inc >= umts_stride(r_version)) begin
                    n_pos = '0;
                    if (idx_inc >= r_umts_cnt) begin
                        n_in_gsm = 1'b1;
                        n_index  = '0;
                    end else begin
                        n_index = idx_inc;
                    end
                end else begin
                    n_pos = pos_inc;
                end
            end
        end

        if (r_offset != OFFSET_MAX) begin
            n_offset = r_offset + 10'd1;
        end

        stat_item.eop = 1'b1;
        if (r_offset < 10'd3) begin
            stat_item.kind = KIND_TOO_SHORT;
        end else if (n_version == VER_NONE) begin
            stat_item.kind = KIND_BAD_VERSION;
        end else begin
            stat_item.kind = KIND_DONE;
        end

        if (i_last_byte) begin
            n_offset   = '0;
            n_version  = VER_0;
            n_umts_cnt = '0;
            n_gsm_cnt  = '0;
            n_in_gsm   = 1'b0;
            n_index    = '0;
            n_pos      = '0;
            n_channel  = '0;
            n_code     = '0;
            n_power    = '0;
            n_bsic     = '0;
            n_serving  = 1'b0;
        end
    end

    assign slot0    = rec_valid ? rec_item : stat_item;
    assign push_cnt = in_acc ? ({1'b0, rec_valid} + {1'b0, i_last_byte}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_version  <= VER_0;
            r_umts_cnt <= '0;
            r_gsm_cnt  <= '0;
            r_in_gsm   <= 1'b0;
            r_index    <= '0;
            r_pos      <= '0;
            r_channel  <= '0;
            r_code     <= '0;
            r_power    <= '0;
            r_bsic     <= '0;
            r_serving  <= 1'b0;
        end else if (in_acc) begin
            r_offset   <= n_offset;
            r_version  <= n_version;
            r_umts_cnt <= n_umts_cnt;
            r_gsm_cnt  <= n_gsm_cnt;
            r_in_gsm   <= n_in_gsm;
            r_index    <= n_index;
            r_pos      <= n_pos;
            r_channel  <= n_channel;
            r_code     <= n_code;
            r_power    <= n_power;
            r_bsic     <= n_bsic;
            r_serving  <= n_serving;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + QUEUE_AW'(1)] <= stat_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QUEUE_AW'(push_cnt);
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            r_count <= r_count + (QUEUE_AW+1)'(push_cnt) - (QUEUE_AW+1)'(out_acc);
        end
    end

    assign head                = r_queue[r_rd_ptr];
    assign o_item_kind         = head.kind;
    assign o_channel_number    = head.channel;
    assign o_scrambling_code   = head.code;
    assign o_rscp_dbm          = head.rscp;
    assign o_ecio_db           = head.ecio;
    assign o_base_station_code = head.bsic;
    assign o_gsm_level         = head.level;
    assign o_end_of_packet     = head.eop;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reselection-rank record parser: feeds directed
// and random log payloads a byte at a time under bursty input and stalling
// output, predicts every cell and status item, and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
    import crrp_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte = 8'h00;
    logic               last_byte = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         item_kind;
    logic [13:0]        channel_number;
    logic [8:0]         scrambling_code;
    logic signed [8:0]  rscp_dbm;
    logic signed [6:0]  ecio_db;
    logic [7:0]         base_station_code;
    logic signed [7:0]  gsm_level;
    logic               end_of_packet;

    // parser state mirror
    logic [9:0]  pr_offset = '0;
    t_version    pr_ver = VER_0;
    logic [5:0]  pr_n3 = '0;
    logic [5:0]  pr_n2 = '0;
    logic        pr_in_gsm = 1'b0;
    logic [5:0]  pr_idx = '0;
    logic [4:0]  pr_pos = '0;
    logic [15:0] pr_chan = '0;
    logic [15:0] pr_code = '0;
    logic [7:0]  pr_power = '0;
    logic [7:0]  pr_bsic = '0;
    logic        pr_serving = 1'b0;

    t_item       items_due[$];
    logic [8:0]  bytes_to_send[$];
    logic [7:0]  pkt_bytes[$];
    logic [8:0]  next_req;

    int errors = 0;
    int reqs_taken = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rx_left = 0;
    int rx_mode = 0;
    int rx_phase = 0;

    cell_reselection_rank_record_parser_core dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_data_byte         (data_byte),
        .i_last_byte         (last_byte),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_item_kind         (item_kind),
        .o_channel_number    (channel_number),
        .o_scrambling_code   (scrambling_code),
        .o_rscp_dbm          (rscp_dbm),
        .o_ecio_db           (ecio_db),
        .o_base_station_code (base_station_code),
        .o_gsm_level         (gsm_level),
        .o_end_of_packet     (end_of_packet)
    );

    always #5 clk = ~clk;

    function automatic logic [5:0] clip_count(input logic [5:0] c);
        return (c > 6'(MAX_ENTRIES)) ? 6'(MAX_ENTRIES) : c;
    endfunction

    function automatic void push_item(input t_kind kind, input int chan, input int code,
                                      input int rscp, input int ecio, input int bsic,
                                      input int level, input logic eop);
        t_item it;
        it.kind    = kind;
        it.channel = 14'(chan);
        it.code    = 9'(code);
        it.rscp    = 9'(rscp);
        it.ecio    = 7'(ecio);
        it.bsic    = 8'(bsic);
        it.level   = 8'(level);
        it.eop     = eop;
        items_due.insert(items_due.size(), it);
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [9:0]  off;
        logic [11:0] arfcn;
        int first, s3, s2, rscp, ecio;
        t_kind status;
        off = pr_offset;
        if (off == 10'd0) begin
            pr_ver = t_version'(b[7:6]);
            pr_n3  = clip_count(b[5:0]);
        end else if (off == 10'd1) begin
            pr_n2     = clip_count(b[5:0]);
            pr_in_gsm = (pr_n3 == 6'd0);
            pr_idx    = '0;
            pr_pos    = '0;
        end
        case (pr_ver)
            VER_0: begin
                first = 2; s3 = 10; s2 = 7;
            end
            VER_1: begin
                first = 2; s3 = 11; s2 = 8;
            end
            VER_2: begin
                first = 7; s3 = 16; s2 = 13;
            end
            default: begin
                first = 0; s3 = 1; s2 = 1;
            end
        endcase
        if (off >= 10'd2 && pr_ver != VER_NONE && off >= 10'(first)) begin
            if (pr_in_gsm) begin
                if (pr_idx < pr_n2) begin
                    case (pr_pos)
                        5'd0: pr_chan = {8'h00, b};
                        5'd1: pr_chan[15:8] = b;
                        5'd2: pr_bsic = b;
                        5'd3: pr_power = b;
                        5'd4: begin
                            arfcn = pr_chan[11:0];
                            if (arfcn >= 12'd1 && arfcn <= 12'd1023) begin
                                push_item(KIND_GSM, int'(arfcn), 0, 0, 0, int'(pr_bsic),
                                          int'($signed(pr_power)), 1'b0);
                            end
                        end
                        default: ;
                    endcase
                    pr_pos = pr_pos + 5'd1;
                    if (pr_pos >= 5'(s2)) begin
                        pr_pos = '0;
                        pr_idx = pr_idx + 6'd1;
                    end
                end
            end else if (pr_idx < pr_n3) begin
                case (pr_pos)
                    5'd0: pr_chan = {8'h00, b};
                    5'd1: pr_chan[15:8] = b;
                    5'd2: pr_code = {8'h00, b};
                    5'd3: pr_code[15:8] = b;
                    5'd4: pr_power = b;
                    5'd7: begin
                        if (pr_code <= 16'd511 && pr_chan >= 16'd1 && pr_chan <= 16'd16383) begin
                            rscp = int'($signed(pr_power)) - 21;
                            if (rscp < -140) rscp = -140;
                            if (rscp > 0) rscp = 0;
                            ecio = int'($signed(b)) / 2;
                            if (ecio < -50) ecio = -50;
                            if (ecio > 0) ecio = 0;
                            push_item(pr_serving ? KIND_NEIGHBOR_3G : KIND_SERVING_3G,
                                      int'(pr_chan), int'(pr_code), rscp, ecio, 0, 0, 1'b0);
                            pr_serving = 1'b1;
                        end
                    end
                    default: ;
                endcase
                pr_pos = pr_pos + 5'd1;
                if (pr_pos >= 5'(s3)) begin
                    pr_pos = '0;
                    pr_idx = pr_idx + 6'd1;
                    if (pr_idx >= pr_n3) begin
                        pr_in_gsm = 1'b1;
                        pr_idx    = '0;
                    end
                end
            end
        end
        if (pr_offset != 10'd1023) begin
            pr_offset = pr_offset + 10'd1;
        end
        if (last) begin
            if (off < 10'd3) begin
                status = KIND_TOO_SHORT;
            end else if (pr_ver == VER_NONE) begin
                status = KIND_BAD_VERSION;
            end else begin
                status = KIND_DONE;
            end
            push_item(status, 0, 0, 0, 0, 0, 0, 1'b1);
            pr_offset  = '0;
            pr_ver     = VER_0;
            pr_n3      = '0;
            pr_n2      = '0;
            pr_in_gsm  = 1'b0;
            pr_idx     = '0;
            pr_pos     = '0;
            pr_chan    = '0;
            pr_code    = '0;
            pr_power   = '0;
            pr_bsic    = '0;
            pr_serving = 1'b0;
        end
    endtask

    task automatic queue_packet();
        int i;
        for (i = 0; i < pkt_bytes.size(); i++) begin
            bytes_to_send.insert(bytes_to_send.size(),
                                 {i == pkt_bytes.size() - 1, pkt_bytes[i]});
        end
        pkt_bytes.delete();
    endtask

    task automatic build_packet(input bit stretch);
        int ver, n3, n2, first, s3, s2, full, len, i, j;
        logic [5:0]  c3, c2;
        logic [15:0] w;
        if (!stretch && $urandom_range(0, 99) < 8) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
                pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
            end
        end else begin
            ver = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
            c3 = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
            c2 = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
            pkt_bytes.insert(pkt_bytes.size(), {2'(ver), c3});
            pkt_bytes.insert(pkt_bytes.size(), {2'($urandom), c2});
            n3 = (c3 > 6'(MAX_ENTRIES)) ? MAX_ENTRIES : int'(c3);
            n2 = (c2 > 6'(MAX_ENTRIES)) ? MAX_ENTRIES : int'(c2);
            case (ver)
                1: begin
                    first = 2; s3 = 11; s2 = 8;
                end
                2: begin
                    first = 7; s3 = 16; s2 = 13;
                end
                default: begin
                    first = 2; s3 = 10; s2 = 7;
                end
            endcase
            for (i = 2; i < first; i++) begin
                pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
            end
            for (i = 0; i < n3; i++) begin
                if ($urandom_range(0, 6) != 0) begin
                    w = 16'($urandom_range(1, 16383));
                end else begin
                    w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(16384, 65535));
                end
                pkt_bytes.insert(pkt_bytes.size(), w[7:0]);
                pkt_bytes.insert(pkt_bytes.size(), w[15:8]);
                if ($urandom_range(0, 6) != 0) begin
                    w = 16'($urandom_range(0, 511));
                end else begin
                    w = 16'($urandom_range(512, 65535));
                end
                pkt_bytes.insert(pkt_bytes.size(), w[7:0]);
                pkt_bytes.insert(pkt_bytes.size(), w[15:8]);
                for (j = 4; j < s3; j++) begin
                    pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
                end
            end
            for (i = 0; i < n2; i++) begin
                w[15:12] = 4'($urandom);
                if ($urandom_range(0, 6) != 0) begin
                    w[11:0] = 12'($urandom_range(1, 1023));
                end else begin
                    w[11:0] = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(1024, 4095));
                end
                pkt_bytes.insert(pkt_bytes.size(), w[7:0]);
                pkt_bytes.insert(pkt_bytes.size(), w[15:8]);
                for (j = 2; j < s2; j++) begin
                    pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
                end
            end
            full = pkt_bytes.size();
            if (stretch) begin
                len = $urandom_range(1030, 1100);
            end else if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, full);
            end else begin
                len = full + $urandom_range(0, 3);
            end
            while (pkt_bytes.size() > len) begin
                void'(pkt_bytes.pop_back());
            end
            while (pkt_bytes.size() < len) begin
                pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
            end
        end
        queue_packet();
    endtask

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // driver: bursty byte requests, no gaps during the output hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                parse_byte(data_byte, last_byte);
                reqs_taken <= reqs_taken + 1;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0 && hold_left == 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (bytes_to_send.size() != 0) begin
                    next_req = bytes_to_send.pop_front();
                    last_byte <= next_req[8];
                    data_byte <= next_req[7:0];
                    in_valid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // hold off the output once, long enough to back up the input
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reqs_taken >= 400) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0:       out_ready <= (hold_left == 0);
            1:       out_ready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
            2:       out_ready <= (hold_left == 0) && (rx_phase % 3 == 0);
            default: out_ready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
        endcase
    end

    // monitor
    always @(posedge clk) begin
        t_item exp_item;
        if (rst_n && out_valid && out_ready) begin
            if (items_due.size() == 0) begin
                $error("unexpected result: item_kind %0d channel_number %0d",
                       item_kind, channel_number);
                errors++;
            end else begin
                exp_item = items_due.pop_front();
                check_field("item_kind", exp_item.kind, item_kind);
                check_field("channel_number", exp_item.channel, channel_number);
                check_field("scrambling_code", exp_item.code, scrambling_code);
                check_field("rscp_dbm", exp_item.rscp, rscp_dbm);
                check_field("ecio_db", exp_item.ecio, ecio_db);
                check_field("base_station_code", exp_item.bsic, base_station_code);
                check_field("gsm_level", exp_item.level, gsm_level);
                check_field("end_of_packet", exp_item.eop, end_of_packet);
            end
        end
    end

    initial begin
        int random_reqs;
        int before_cnt;
        bit long_sent;
        random_reqs = 0;
        long_sent   = 1'b0;

        pkt_bytes = '{8'hFF};
        queue_packet();
        pkt_bytes = '{8'h00, 8'h00, 8'h00};
        queue_packet();
        pkt_bytes = '{8'hC5, 8'h05, 8'hAA, 8'h55};
        queue_packet();
        // full-range 3G record, then a GSM record that ends the packet
        pkt_bytes = '{8'h01, 8'h01,
                      8'hFF, 8'h3F, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h00, 8'h81, 8'h00, 8'h00,
                      8'hFF, 8'hF3, 8'hFF, 8'h80, 8'h5A};
        queue_packet();

        while (random_reqs < 1250) begin
            before_cnt = bytes_to_send.size();
            if (!long_sent && random_reqs > 600) begin
                build_packet(1'b1);
                long_sent = 1'b1;
            end
            build_packet(1'b0);
            random_reqs += bytes_to_send.size() - before_cnt;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_to_send.size() != 0 || in_valid) begin
            @(posedge clk);
        end
        while (items_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[files.f]
sv/crrp_pkg.sv
sv/cell_reselection_rank_record_parser_core.sv
dv/tb_top.sv
